[sv/tlt_pkg.sv]
package tlt_pkg;

    // Field widths
    localparam int LENGTH_BITS   = 8;
    localparam int POSITION_BITS = 16;
    localparam int LINE_BITS     = 16;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Token kinds
    localparam logic [2:0] K_END = 3'd0;
    localparam logic [2:0] K_SEP = 3'd1;
    localparam logic [2:0] K_OP  = 3'd2;
    localparam logic [2:0] K_INT = 3'd3;
    localparam logic [2:0] K_DEC = 3'd4;
    localparam logic [2:0] K_ID  = 3'd5;
    localparam logic [2:0] K_RES = 3'd6;
    localparam logic [2:0] K_BAD = 3'd7;

    // Scanner modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_IDENT  = 2'd2;
    localparam logic [1:0] MODE_PAIR   = 2'd3;

    // Reserved words: integer, double, if, output, fn, return
    localparam int NUM_WORDS = 6;
    localparam logic [7:0] KW_CHARS [0:NUM_WORDS-1][0:7] = '{
        '{"i", "n", "t", "e", "g", "e", "r", 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "u", "t", "p", "u", "t", 8'h00, 8'h00},
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };
    localparam logic [LENGTH_BITS-1:0] KW_LEN [0:NUM_WORDS-1] = '{
        LENGTH_BITS'(7), LENGTH_BITS'(6), LENGTH_BITS'(2),
        LENGTH_BITS'(6), LENGTH_BITS'(2), LENGTH_BITS'(6)
    };

    typedef struct packed {
        logic [2:0]               kind;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   length;
        logic [LINE_BITS-1:0]     line;
    } token_t;

    typedef struct packed {
        token_t tok;
        logic   last;
    } result_t;

    // Up to two results per accepted byte, r0 first
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
    endfunction

    function automatic logic is_number_end(input logic [7:0] b);
        return b inside {8'h00, " ", 8'h0a, "(", ")", "{", "}", ",", ";",
                         "+", "-", "*", "/", "<", ">", "=", "!"};
    endfunction

    function automatic logic is_ident_end(input logic [7:0] b);
        return (b == ":") || is_number_end(b);
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + LENGTH_BITS'(1);
    endfunction

    // Drop the words that do not have byte b at place p
    function automatic logic [NUM_WORDS-1:0] kw_match(input logic [NUM_WORDS-1:0]   hits,
                                                      input logic [LENGTH_BITS-1:0] p,
                                                      input logic [7:0]             b);
        logic [NUM_WORDS-1:0] m;
        m = hits;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if ((p >= KW_LEN[i]) || (KW_CHARS[i][p[2:0]] != b))
                m[i] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic kw_reserved(input logic [NUM_WORDS-1:0]   hits,
                                         input logic [LENGTH_BITS-1:0] len);
        logic r;
        r = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (hits[i] && (len == KW_LEN[i]))
                r = 1'b1;
        end
        return r;
    endfunction

endpackage

[sv/tlt_lexer.sv]
module tlt_lexer
    import tlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_byte,
    output push_t      push
);

    typedef struct packed {
        logic [7:0]               held;
        logic [1:0]               mode;
        logic                     dot;
        logic [2:0]               kind;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   length;
        logic [NUM_WORDS-1:0]     hits;
        logic [POSITION_BITS-1:0] pos;
        logic [LINE_BITS-1:0]     line;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        held:   8'h00,
        mode:   MODE_START,
        dot:    1'b0,
        kind:   K_END,
        start:  '0,
        length: '0,
        hits:   {NUM_WORDS{1'b1}},
        pos:    '0,
        line:   LINE_BITS'(1)
    };

    scan_t  scan_reg;
    scan_t  scan_next;
    token_t t_mode;
    token_t t_feed;
    logic   e_mode;
    logic   e_feed;
    logic   feed;
    logic   ended;
    logic   pair_op;
    logic   pair_sep;

    // Scanner next state and emitted tokens for the current byte
    always_comb
    begin
        scan_next = scan_reg;
        feed      = 1'b1;
        ended     = 1'b0;
        e_mode    = 1'b0;
        e_feed    = 1'b0;
        t_mode    = '{kind: scan_reg.kind, start: scan_reg.start,
                      length: scan_reg.length, line: scan_reg.line};
        t_feed    = '{kind: K_END, start: scan_reg.pos,
                      length: LENGTH_BITS'(1), line: scan_reg.line};
        pair_op   = 1'b0;
        pair_sep  = 1'b0;

        // Token in progress
        case (scan_reg.mode)
            MODE_NUMBER:
            begin
                if (is_number_end(char_byte))
                begin
                    e_mode         = 1'b1;
                    scan_next.mode = MODE_START;
                end
                else if (is_digit(char_byte))
                begin
                    scan_next.length = sat_inc(scan_reg.length);
                    feed             = 1'b0;
                end
                else if ((char_byte == ".") && !scan_reg.dot)
                begin
                    scan_next.dot    = 1'b1;
                    scan_next.kind   = K_DEC;
                    scan_next.length = sat_inc(scan_reg.length);
                    feed             = 1'b0;
                end
                else
                begin
                    scan_next.length = sat_inc(scan_reg.length);
                    t_mode.kind      = K_BAD;
                    t_mode.length    = scan_next.length;
                    e_mode           = 1'b1;
                    scan_next.mode   = MODE_START;
                    feed             = 1'b0;
                end
            end
            MODE_IDENT:
            begin
                if (is_ident_end(char_byte))
                begin
                    t_mode.kind    = kw_reserved(scan_reg.hits, scan_reg.length) ? K_RES : K_ID;
                    e_mode         = 1'b1;
                    scan_next.mode = MODE_START;
                end
                else if (is_letter(char_byte))
                begin
                    scan_next.hits   = kw_match(scan_reg.hits, scan_reg.length, char_byte);
                    scan_next.length = sat_inc(scan_reg.length);
                    feed             = 1'b0;
                end
                else
                begin
                    scan_next.length = sat_inc(scan_reg.length);
                    t_mode.kind      = K_BAD;
                    t_mode.length    = scan_next.length;
                    e_mode           = 1'b1;
                    scan_next.mode   = MODE_START;
                    feed             = 1'b0;
                end
            end
            MODE_PAIR:
            begin
                pair_op  = ((scan_reg.held inside {":", ">", "!", "="}) && (char_byte == "="))
                        || ((scan_reg.held == "<") && (char_byte inside {"<", "="}));
                pair_sep = (scan_reg.held == "=") && (char_byte == ">");
                e_mode   = 1'b1;
                if (pair_op || pair_sep)
                begin
                    t_mode.kind   = pair_op ? K_OP : K_SEP;
                    t_mode.length = sat_inc(scan_reg.length);
                    feed          = 1'b0;
                end
                else
                begin
                    t_mode.kind = (scan_reg.held inside {"!", "="}) ? K_BAD : K_OP;
                end
                scan_next.mode = MODE_START;
            end
            default:
            begin
                scan_next.mode = MODE_START;
            end
        endcase

        // Byte at token start
        if (feed)
        begin
            case (char_byte)
                8'h00:
                begin
                    e_feed        = 1'b1;
                    t_feed.kind   = K_END;
                    t_feed.length = '0;
                    scan_next     = SCAN_RESET;
                    ended         = 1'b1;
                end
                " ":
                begin
                end
                8'h0a:
                begin
                    scan_next.line = scan_reg.line + LINE_BITS'(1);
                end
                "(", ")", "{", "}", ",", ";":
                begin
                    e_feed      = 1'b1;
                    t_feed.kind = K_SEP;
                end
                "+", "-", "*", "/":
                begin
                    e_feed      = 1'b1;
                    t_feed.kind = K_OP;
                end
                ":", "<", ">", "!", "=":
                begin
                    scan_next.mode   = MODE_PAIR;
                    scan_next.held   = char_byte;
                    scan_next.start  = scan_reg.pos;
                    scan_next.length = LENGTH_BITS'(1);
                end
                default:
                begin
                    if (is_digit(char_byte))
                    begin
                        scan_next.mode   = MODE_NUMBER;
                        scan_next.kind   = K_INT;
                        scan_next.dot    = 1'b0;
                        scan_next.start  = scan_reg.pos;
                        scan_next.length = LENGTH_BITS'(1);
                    end
                    else if (is_letter(char_byte))
                    begin
                        scan_next.mode   = MODE_IDENT;
                        scan_next.kind   = K_ID;
                        scan_next.start  = scan_reg.pos;
                        scan_next.hits   = kw_match({NUM_WORDS{1'b1}}, '0, char_byte);
                        scan_next.length = LENGTH_BITS'(1);
                    end
                    else
                    begin
                        e_feed      = 1'b1;
                        t_feed.kind = K_BAD;
                    end
                end
            endcase
        end

        if (!ended)
            scan_next.pos = scan_reg.pos + POSITION_BITS'(1);
    end

    // Order the results, mark the last one
    always_comb
    begin
        push.r0 = '{tok: t_mode, last: !e_feed};
        push.r1 = '{tok: t_feed, last: 1'b1};
        if (e_mode)
        begin
            push.count = e_feed ? 2'd2 : 2'd1;
        end
        else
        begin
            push.r0    = '{tok: t_feed, last: 1'b1};
            push.count = e_feed ? 2'd1 : 2'd0;
        end
        if (!accept)
            push.count = 2'd0;
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= SCAN_RESET;
        else if (accept)
            scan_reg <= scan_next;
    end

endmodule

[sv/tlt_queue.sv]
module tlt_queue
    import tlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int DEPTH = 4;

    result_t    mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    // room for two results from the next byte
    assign space     = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/toy_language_tokenizer_core.sv]
// Streaming tokenizer for a small toy language.
// Slave channel: one text byte per request in s_axis_tdata; a zero byte ends
// the text, emits an END token and returns the scanner to its reset state.
// Master channel: one token per request in m_axis_tdata (kind, start offset,
// length, line); m_axis_tlast marks the last token caused by one input byte.
// A byte gives zero, one or two tokens. Tokens are registered in the result queue
// when the byte that completes them is accepted.
// Throughput: one byte per cycle while the master side keeps up. The scanner
// state is registered and updates with each accepted byte; tokens pass through a four-entry
// result queue, and s_axis_tready is high while at least two entries are free.
// Two bytes that each yield two tokens never follow one another, so with the
// master side always ready the queue holds at most two tokens and never stops input.
// Reset (rst_n low) clears the scanner to line 1, offset 0, and empties the
// queue. When the receiver stalls, queued tokens hold and input stops once
// fewer than two entries are free.
module toy_language_tokenizer_core
    import tlt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [2:0] token_kind, [18:3] token_start,
                                        // [26:19] token_length, [42:27] token_line, zero fill
    output logic        m_axis_tlast    // last_of_step
);

    localparam int TOK_BITS = 3 + POSITION_BITS + LENGTH_BITS + LINE_BITS;

    push_t   push;
    result_t out_data;
    logic    space;
    logic    accept;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    // Scanner
    tlt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_byte (s_axis_tdata),
        .push      (push)
    );

    // Result queue
    tlt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Pack token fields, kind in the lowest bits
    assign m_axis_tdata = {{(48 - TOK_BITS){1'b0}},
                           out_data.tok.line,
                           out_data.tok.length,
                           out_data.tok.start,
                           out_data.tok.kind};
    assign m_axis_tlast = out_data.last;

endmodule
